/* sv/conv3x3_gain_offset_clamp_macros.svh */
// assertion macros for the 3x3 convolution block
`ifndef CONV3X3_GAIN_OFFSET_CLAMP_MACROS_SVH
`define CONV3X3_GAIN_OFFSET_CLAMP_MACROS_SVH
`ifndef SYNTHESIS
`define CGOC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CGOC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CGOC_ASSERT_IMP(lbl, ante, cons, msg)
`define CGOC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/cgoc_pkg.sv */
// shared types and constants of the 3x3 convolution block
package cgoc_pkg;

  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int KERN_W       = 24;
  localparam int GAIN_W       = 24;
  localparam int OFFSET_W     = 11;
  localparam int IN_ROW_W     = 13;
  localparam int OUT_ROW_W    = 12;
  localparam int CFG_AW       = 5;

  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_CAP = 13'd4096;
  localparam logic [HEIGHT_REG_W-1:0] MIN_DIM    = 13'd3;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_K_TOP  = 3'd2;
  localparam logic [2:0] REG_K_MID  = 3'd3;
  localparam logic [2:0] REG_K_BOT  = 3'd4;
  localparam logic [2:0] REG_GAIN   = 3'd5;
  localparam logic [2:0] REG_OFFSET = 3'd6;

  localparam logic [WIDTH_REG_W-1:0]  RST_WIDTH  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [KERN_W-1:0]       RST_K_TOP  = 24'h000000;
  localparam logic [KERN_W-1:0]       RST_K_MID  = 24'h000100;
  localparam logic [KERN_W-1:0]       RST_K_BOT  = 24'h000000;
  localparam logic [GAIN_W-1:0]       RST_GAIN   = 24'h010000;
  localparam logic [OFFSET_W-1:0]     RST_OFFSET = 11'd0;

  typedef logic [7:0] pix_t;
  typedef logic [2:0][2:0][7:0] win_t;
  typedef logic [2:0][KERN_W-1:0] kern_t;

  typedef struct packed {
    logic start;
    pix_t centre;
  } filt_ctrl_t;

  typedef struct packed {
    logic done;
    pix_t value;
  } filt_stat_t;

endpackage

/* sv/cgoc_line_mem.sv */
// line store holding the upper and middle row pixel of each column
module cgoc_line_mem #(
  parameter int LINE_MAX = 2048
) (
  input  logic                        clk,
  input  logic                        re,
  input  logic                        we,
  input  logic [$clog2(LINE_MAX)-1:0] addr,
  input  logic [15:0]                 wdata,
  output logic [15:0]                 rdata
);
  import cgoc_pkg::*;

  logic [15:0] mem [LINE_MAX];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/cgoc_filter.sv */
// kernel multiply-accumulate, gain, offset, magnitude, clamp and rounding
`include "conv3x3_gain_offset_clamp_macros.svh"
module cgoc_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cgoc_pkg::filt_ctrl_t           ctrl,
  input  cgoc_pkg::win_t                 win,
  input  cgoc_pkg::kern_t                kern,
  input  logic [cgoc_pkg::GAIN_W-1:0]    gain,
  input  logic [cgoc_pkg::OFFSET_W-1:0]  offset,
  output cgoc_pkg::filt_stat_t           stat
);
  import cgoc_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MAC  = 4'b0010,
    F_MUL  = 4'b0100,
    F_FIN  = 4'b1000
  } fst_t;

  localparam logic [44:0] CLAMP_LIM  = 45'(255) << 16;
  localparam logic [23:0] ROUND_HALF = 24'h008000;

  fst_t               fst_r, fst_nxt;
  logic [1:0]         row_r, row_nxt;
  logic signed [19:0] acc_r, acc_nxt;
  logic signed [43:0] prod_r;

  logic [KERN_W-1:0]  taps;
  logic [2:0][7:0]    prow;
  logic signed [16:0] prd [3];
  logic signed [18:0] row_sum;
  logic signed [44:0] psum;
  logic [44:0]        mag;
  logic [23:0]        rnd;

  always_comb begin
    case (row_r)
      2'd0: begin
        taps = kern[0];
        prow = win[0];
      end
      2'd1: begin
        taps = kern[1];
        prow = win[1];
      end
      default: begin
        taps = kern[2];
        prow = win[2];
      end
    endcase
    for (int c = 0; c < 3; c++) begin
      prd[c] = $signed(taps[8*c +: 8]) * $signed({1'b0, prow[c]});
    end
    row_sum = 19'(prd[0]) + 19'(prd[1]) + 19'(prd[2]);
  end

  always_comb begin
    fst_nxt = fst_r;
    row_nxt = row_r;
    acc_nxt = acc_r;
    case (fst_r)
      F_IDLE: begin
        if (ctrl.start) begin
          row_nxt = 2'd0;
          if (offset != '0) begin
            acc_nxt = $signed({12'b0, ctrl.centre});
            fst_nxt = F_MUL;
          end else begin
            acc_nxt = '0;
            fst_nxt = F_MAC;
          end
        end
      end
      F_MAC: begin
        acc_nxt = acc_r + 20'(row_sum);
        row_nxt = row_r + 2'd1;
        if (row_r == 2'd2) begin
          fst_nxt = F_MUL;
        end
      end
      F_MUL: fst_nxt = F_FIN;
      F_FIN: fst_nxt = F_IDLE;
      default: fst_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= F_IDLE;
      row_r <= 2'd0;
    end else begin
      fst_r <= fst_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (fst_r == F_MUL) begin
      prod_r <= $signed(gain) * acc_r;
    end
  end

  // offset is zero in convolution mode, so it can always be added
  always_comb begin
    psum = {prod_r[43], prod_r} + $signed({{18{offset[OFFSET_W-1]}}, offset, 16'b0});
    mag  = psum[44] ? 45'(-psum) : 45'(psum);
    rnd  = mag[23:0] + ROUND_HALF;
    stat.done  = (fst_r == F_FIN);
    stat.value = (mag > CLAMP_LIM) ? 8'd255 : rnd[23:16];
  end

  `CGOC_ASSERT_IMP(a_start_idle, ctrl.start, fst_r == F_IDLE, "filter started while busy")

endmodule

/* sv/conv3x3_gain_offset_clamp.sv */
// Raster-order 3x3 convolution with Q8.16 gain, optional point offset, magnitude,
// clamp to 255 and round half up; the one-pixel border passes unchanged. Items are
// handled one at a time: an early flush is dropped; others shift into the window
// after the registered line store read. Border results go straight out; others pass
// the filter, whose row-by-row kernel accumulate (skipped for a point transform)
// precedes the single gain multiplier. The result register lets the next item enter
// while a finished result waits. Results lag input by width+1 items; width+1 flush
// items after the last pixel drain the frame. The line store has no clearing pass
// and is valid from reset for any frame run under stable settings.
`include "conv3x3_gain_offset_clamp_macros.svh"
module conv3x3_gain_offset_clamp #(
  parameter int LINE_MAX = 2048
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_pixel,
  input  logic                         in_flush,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_pixel,
  output logic                         out_last_of_frame,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cgoc_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import cgoc_pkg::*;

  localparam int CW = $clog2(LINE_MAX);
  localparam int WW = $clog2(LINE_MAX + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SHIFT = 4'b0010,
    ST_FILT  = 4'b0100,
    ST_OUT   = 4'b1000
  } st_t;

  logic [WIDTH_REG_W-1:0]  image_width_r;
  logic [HEIGHT_REG_W-1:0] image_height_r;
  logic [KERN_W-1:0]       kernel_row_top_r, kernel_row_mid_r, kernel_row_bot_r;
  logic [GAIN_W-1:0]       gain_r;
  logic [OFFSET_W-1:0]     offset_r;

  st_t                 st_r, st_nxt;
  logic [CW-1:0]       in_col_r, in_col_nxt;
  logic [IN_ROW_W-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0]       out_col_r, out_col_nxt;
  logic [OUT_ROW_W-1:0] out_row_r, out_row_nxt;
  win_t                win_r, win_nxt;
  logic                out_valid_r, out_valid_nxt;

  pix_t pix_r, res_r, out_pixel_r;
  logic res_last_r, out_last_r;

  logic [WW-1:0]           w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic                    in_accept, draining, take;
  logic                    emit, border, last, out_load, cfg_wr;
  logic [CW:0]             col_inc, ocol_inc;
  logic [15:0]             mem_rdata;
  kern_t                   kern;
  filt_ctrl_t              filt_ctrl;
  filt_stat_t              filt_stat;

  always_comb begin
    if (image_width_r < 12'd3) begin
      w_eff = WW'(3);
    end else if (32'(image_width_r) > 32'(LINE_MAX)) begin
      w_eff = WW'(LINE_MAX);
    end else begin
      w_eff = WW'(image_width_r);
    end
    if (image_height_r < MIN_DIM) begin
      h_eff = MIN_DIM;
    end else if (image_height_r > HEIGHT_CAP) begin
      h_eff = HEIGHT_CAP;
    end else begin
      h_eff = image_height_r;
    end
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign draining  = (in_row_r >= h_eff);
  // an early flush is taken and dropped
  assign take      = in_accept && !(in_flush && !draining);

  assign col_inc  = {1'b0, in_col_r} + (CW+1)'(1);
  assign ocol_inc = {1'b0, out_col_r} + (CW+1)'(1);
  assign emit     = (in_row_r >= 13'd2) || (in_row_r == 13'd1 && in_col_r != '0);
  assign last     = (13'(out_row_r) >= h_eff - 13'd1) &&
                    (32'(out_col_r) >= 32'(w_eff) - 32'd1);
  assign border   = (out_row_r == '0) || (out_col_r == '0) ||
                    (13'(out_row_r) >= h_eff - 13'd1) ||
                    (32'(out_col_r) >= 32'(w_eff) - 32'd1);
  assign out_load = (st_r == ST_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    st_nxt      = st_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    win_nxt     = win_r;
    case (st_r)
      ST_IDLE: begin
        if (take) begin
          st_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 2; c++) begin
            win_nxt[r][c] = win_r[r][c+1];
          end
        end
        win_nxt[0][2] = mem_rdata[15:8];
        win_nxt[1][2] = mem_rdata[7:0];
        win_nxt[2][2] = pix_r;
        if (32'(col_inc) >= 32'(w_eff)) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + 13'd1;
        end else begin
          in_col_nxt = col_inc[CW-1:0];
        end
        if (!emit) begin
          st_nxt = ST_IDLE;
        end else begin
          st_nxt = border ? ST_OUT : ST_FILT;
          if (last) begin
            in_col_nxt  = '0;
            in_row_nxt  = '0;
            out_col_nxt = '0;
            out_row_nxt = '0;
          end else if (32'(ocol_inc) >= 32'(w_eff)) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + 12'd1;
          end else begin
            out_col_nxt = ocol_inc[CW-1:0];
          end
        end
      end
      ST_FILT: begin
        if (filt_stat.done) begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r             <= ST_IDLE;
      in_col_r         <= '0;
      in_row_r         <= '0;
      out_col_r        <= '0;
      out_row_r        <= '0;
      win_r            <= '0;
      out_valid_r      <= 1'b0;
      image_width_r    <= RST_WIDTH;
      image_height_r   <= RST_HEIGHT;
      kernel_row_top_r <= RST_K_TOP;
      kernel_row_mid_r <= RST_K_MID;
      kernel_row_bot_r <= RST_K_BOT;
      gain_r           <= RST_GAIN;
      offset_r         <= RST_OFFSET;
    end else begin
      st_r        <= st_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      win_r       <= win_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_WIDTH:  image_width_r    <= pwdata[WIDTH_REG_W-1:0];
          REG_HEIGHT: image_height_r   <= pwdata[HEIGHT_REG_W-1:0];
          REG_K_TOP:  kernel_row_top_r <= pwdata[KERN_W-1:0];
          REG_K_MID:  kernel_row_mid_r <= pwdata[KERN_W-1:0];
          REG_K_BOT:  kernel_row_bot_r <= pwdata[KERN_W-1:0];
          REG_GAIN:   gain_r           <= pwdata[GAIN_W-1:0];
          REG_OFFSET: offset_r         <= pwdata[OFFSET_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // centre of the emitted pixel is the middle row's newest tap before the shift
  always_ff @(posedge clk) begin
    if (take) begin
      pix_r <= draining ? 8'd0 : in_pixel;
    end
    if (st_r == ST_SHIFT && emit) begin
      res_r      <= win_r[1][2];
      res_last_r <= last;
    end
    if (st_r == ST_FILT && filt_stat.done) begin
      res_r <= filt_stat.value;
    end
    if (out_load) begin
      out_pixel_r <= res_r;
      out_last_r  <= res_last_r;
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_WIDTH:  prdata = 32'(image_width_r);
      REG_HEIGHT: prdata = 32'(image_height_r);
      REG_K_TOP:  prdata = 32'(kernel_row_top_r);
      REG_K_MID:  prdata = 32'(kernel_row_mid_r);
      REG_K_BOT:  prdata = 32'(kernel_row_bot_r);
      REG_GAIN:   prdata = 32'(gain_r);
      REG_OFFSET: prdata = 32'(offset_r);
      default:    prdata = '0;
    endcase
  end

  assign pready            = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_pixel         = out_pixel_r;
  assign out_last_of_frame = out_last_r;

  assign kern             = {kernel_row_bot_r, kernel_row_mid_r, kernel_row_top_r};
  assign filt_ctrl.start  = (st_r == ST_SHIFT) && emit && !border;
  assign filt_ctrl.centre = win_r[1][2];

  cgoc_line_mem #(
    .LINE_MAX(LINE_MAX)
  ) u_line_mem (
    .clk   (clk),
    .re    (take),
    .we    (st_r == ST_SHIFT),
    .addr  (in_col_r),
    .wdata ({mem_rdata[7:0], pix_r}),
    .rdata (mem_rdata)
  );

  cgoc_filter u_filter (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (filt_ctrl),
    .win    (win_r),
    .kern   (kern),
    .gain   (gain_r),
    .offset (offset_r),
    .stat   (filt_stat)
  );

  `CGOC_ASSERT_IMP(a_done_in_filt, filt_stat.done, st_r == ST_FILT, "filter result outside wait")
  `CGOC_ASSERT_IMP(a_last_clears, out_load && res_last_r, in_row_r == '0 && out_row_r == '0, "frame end did not clear counters")
  `CGOC_ASSERT_NXT(a_hold_result, st_r == ST_OUT && out_valid_r && out_stall, st_r == ST_OUT, "pending result overwritten")

endmodule
